@@ src/mavg_pkg.sv @@
// Package for the moving average filter: shared constants and state types.
// Used by the top level and by the sequential divider; no dependencies.
package mavg_pkg;

   // Width of the window length register and of anything that holds a window count.
   localparam int CFG_BITS = 7;

   // Window length after reset.
   localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd8;

   // Control states of the top level, one-hot.
   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_UPDATE = 4'b0010,
      S_START  = 4'b0100,
      S_DIVIDE = 4'b1000
   } mavg_state_type;

   // Control states of the divider, one-hot.
   typedef enum logic [2:0] {
      DIV_IDLE = 3'b001,
      DIV_RUN  = 3'b010,
      DIV_SIGN = 3'b100
   } mavg_div_state_type;

endpackage

@@ src/mavg_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used by the moving average filter for its sample ring.
module mavg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_BITS-1:0]     wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [ADDR_BITS-1:0]     rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/mavg_div.sv @@
// Sequential restoring divider: signed dividend over unsigned divisor,
// quotient truncated toward zero, one quotient bit per cycle. Uses mavg_pkg.
module mavg_div
   import mavg_pkg::*;
#(
   parameter int DIVIDEND_BITS = 22,
   parameter int DIVISOR_BITS  = 7
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [DIVIDEND_BITS-1:0] dividend,
   input  logic        [DIVISOR_BITS-1:0]  divisor,
   output logic                            done,
   output logic signed [DIVIDEND_BITS-1:0] quotient
);
   localparam int CNT_BITS = (DIVIDEND_BITS > 1) ? $clog2(DIVIDEND_BITS) : 1;

   mavg_div_state_type state_ff, state_in;
   logic [CNT_BITS-1:0]             count_ff, count_in;
   logic                            done_ff, done_in;
   logic [DIVISOR_BITS-1:0]         rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]         divisor_ff, divisor_in;
   logic [DIVIDEND_BITS-1:0]        quo_ff, quo_in;
   logic                            neg_ff, neg_in;
   logic signed [DIVIDEND_BITS-1:0] result_ff, result_in;
   logic [DIVISOR_BITS:0]           trial;
   logic                            fits;

   // One restoring step: bring down the next dividend bit and try the subtract.
   assign trial = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      done_in    = done_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      neg_in     = neg_ff;
      result_in  = result_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               // Latch the magnitude and sign; the quotient register shifts the
               // dividend out at the top while quotient bits enter at the bottom.
               neg_in     = dividend[DIVIDEND_BITS-1];
               quo_in     = dividend[DIVIDEND_BITS-1] ? (-dividend) : dividend;
               divisor_in = divisor;
               rem_in     = '0;
               count_in   = '0;
               done_in    = 1'b0;
               state_in   = DIV_RUN;
            end
         end
         DIV_RUN: begin
            if (fits) begin
               rem_in = DIVISOR_BITS'(trial - {1'b0, divisor_ff});
            end else begin
               rem_in = trial[DIVISOR_BITS-1:0];
            end
            quo_in   = {quo_ff[DIVIDEND_BITS-2:0], fits};
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_BITS'(DIVIDEND_BITS - 1)) begin
               state_in = DIV_SIGN;
            end
         end
         DIV_SIGN: begin
            // Restore the sign, which truncates toward zero.
            result_in = neg_ff ? (-$signed(quo_ff)) : $signed(quo_ff);
            done_in   = 1'b1;
            state_in  = DIV_IDLE;
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
      neg_ff     <= neg_in;
      result_ff  <= result_in;
   end

   assign done     = done_ff;
   assign quotient = result_ff;

endmodule

@@ src/moving_average_filter.sv @@
// Moving average filter top level: sample ring RAM, running total, divider.
// Depends on mavg_pkg, mavg_ram and mavg_div.
//
// Boxcar moving average of signed samples. Each accepted sample yields one
// result: the sum of the last window_length samples divided by the window,
// truncated toward zero. The first sample after reset or after a window write
// stands for the whole window and is returned unchanged. A window of 0 acts
// as 1 and one above MAX_WINDOW acts as MAX_WINDOW. One sample is processed at
// a time, in these steps from transfer to result: a total update that uses the
// ring entry read at the transfer, a divider launch, the quotient bits of the
// restoring divider, a sign fix and the load of the output register, which
// waits while a stalled result still holds that register. A new sample is
// taken once the previous result has been loaded into the output register,
// even while that result still waits there. The window register is written
// through the csr port, which is ready whenever no sample is in flight.
module moving_average_filter
   import mavg_pkg::*;
#(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_average,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CFG_BITS-1:0]           csr_window_length
);
   localparam int ADDR_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int TOTAL_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);

   mavg_state_type state_ff, state_in;
   logic [CFG_BITS-1:0]          window_ff, window_in;
   logic [ADDR_BITS-1:0]         pos_ff, pos_in;
   logic [CFG_BITS-1:0]          ovr_ff, ovr_in;
   logic                         first_pending_ff, first_pending_in;
   logic signed [SAMPLE_BITS-1:0] first_ff, first_in;
   logic signed [TOTAL_BITS-1:0] total_ff, total_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_average_ff, rsp_average_in;

   logic [CFG_BITS-1:0]          eff_window;
   logic [ADDR_BITS:0]           pos_inc;
   logic [ADDR_BITS-1:0]         pos_next;
   logic signed [SAMPLE_BITS-1:0] oldest;
   logic signed [SAMPLE_BITS+CFG_BITS:0] fill_product;
   logic                         req_xfer;
   logic                         csr_xfer;
   logic                         out_free;
   logic                         ram_wr_en;
   logic [SAMPLE_BITS-1:0]       ram_rd_data;
   logic                         div_start;
   logic                         div_done;
   logic signed [TOTAL_BITS-1:0] div_quotient;

   // Handshakes. A pending configuration write holds off new samples.
   assign req_stall = (state_ff != S_IDLE) | csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid & ~req_stall;
   assign csr_xfer  = csr_valid & csr_ready;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   // Effective window: zero acts as one, and the ring depth is the ceiling.
   always_comb begin
      if (window_ff == '0) begin
         eff_window = CFG_BITS'(1);
      end else if (32'(window_ff) > 32'(MAX_WINDOW)) begin
         eff_window = CFG_BITS'(MAX_WINDOW);
      end else begin
         eff_window = window_ff;
      end
   end

   // Next ring position, wrapping at the window length.
   assign pos_inc  = {1'b0, pos_ff} + 1'b1;
   assign pos_next = (32'(pos_inc) >= 32'(eff_window)) ? '0 : pos_inc[ADDR_BITS-1:0];

   // The entry leaving the window; entries never overwritten stand for the first sample.
   assign oldest = (ovr_ff < eff_window) ? first_ff : $signed(ram_rd_data);

   // Total of a window filled with the first sample.
   assign fill_product = sample_ff * $signed({1'b0, eff_window});

   // Sample ring.
   assign ram_wr_en = (state_ff == S_UPDATE) & ~first_pending_ff;

   mavg_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos_next),
      .wr_data (sample_ff),
      .rd_addr (pos_next),
      .rd_data (ram_rd_data)
   );

   // Divider for total over window.
   assign div_start = (state_ff == S_START);

   mavg_div #(
      .DIVIDEND_BITS (TOTAL_BITS),
      .DIVISOR_BITS  (CFG_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_ff),
      .divisor  (eff_window),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Sequencer: take window writes, read the ring, update the total, divide, hand off the result.
   always_comb begin
      state_in         = state_ff;
      window_in        = window_ff;
      pos_in           = pos_ff;
      ovr_in           = ovr_ff;
      first_pending_in = first_pending_ff;
      first_in         = first_ff;
      total_in         = total_ff;
      sample_in        = sample_ff;
      rsp_valid_in     = rsp_valid_ff & rsp_stall;
      rsp_average_in   = rsp_average_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (csr_xfer) begin
               // A window write re-arms the first-sample fill.
               window_in        = csr_window_length;
               pos_in           = '0;
               ovr_in           = '0;
               first_pending_in = 1'b1;
            end else if (req_xfer) begin
               sample_in = req_sample;
               state_in  = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (first_pending_ff) begin
               first_pending_in = 1'b0;
               first_in         = sample_ff;
               total_in         = TOTAL_BITS'(fill_product);
               ovr_in           = '0;
               if (32'(pos_ff) >= 32'(eff_window)) begin
                  pos_in = '0;
               end
            end else begin
               pos_in   = pos_next;
               total_in = total_ff - TOTAL_BITS'(oldest) + TOTAL_BITS'(sample_ff);
               if (ovr_ff < eff_window) begin
                  ovr_in = ovr_ff + 1'b1;
               end
            end
            state_in = S_START;
         end
         S_START: begin
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (div_done && out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_average_in = SAMPLE_BITS'(div_quotient);
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         window_ff        <= CFG_RESET;
         pos_ff           <= '0;
         ovr_ff           <= '0;
         first_pending_ff <= 1'b1;
         first_ff         <= '0;
         total_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         window_ff        <= window_in;
         pos_ff           <= pos_in;
         ovr_ff           <= ovr_in;
         first_pending_ff <= first_pending_in;
         first_ff         <= first_in;
         total_ff         <= total_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sample_ff      <= sample_in;
      rsp_average_ff <= rsp_average_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

   // A sample transfer and a window write never land in the same cycle.
   assert property (@(posedge clock) disable iff (reset) !(req_xfer && csr_xfer))
      else $error("sample transfer and window write in the same cycle");

   // The overwrite count saturates at the effective window.
   assert property (@(posedge clock) disable iff (reset) ovr_ff <= eff_window)
      else $error("overwrite count beyond the window");

   // The ring position stays inside the window.
   assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) < 32'(eff_window))
      else $error("ring position outside the window");

   // A result is handed off only from a finished division.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVIDE) && !div_done |=> (state_ff == S_DIVIDE))
      else $error("left the divide state before the quotient was ready");

endmodule

@@ test/moving_average_filter_test.sv @@
// Self-checking testbench for the moving average filter: directed window cases,
// random sample streams with sender gaps, receiver stalls and a long hold-off.
// Depends on mavg_pkg and the moving_average_filter RTL only.
`timescale 1ns / 1ps

module moving_average_filter_test
   import mavg_pkg::*;
();

   localparam int SAMPLE_W     = 16;
   localparam int RING_DEPTH   = 64;
   localparam int SUM_W        = 22;
   localparam int DRAIN_CYCLES = 40;
   localparam int LIMIT_CYCLES = 800000;

   // Receiver stall patterns, each held for a stretch of cycles.
   typedef enum int {
      STALL_OFF,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_pattern_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic signed [SAMPLE_W-1:0]   req_sample;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0]   rsp_average;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [CFG_BITS-1:0]          csr_window_length;

   // Predicted filter state.
   logic [CFG_BITS-1:0]          window_reg;
   logic signed [SAMPLE_W-1:0]   ring_model [RING_DEPTH];
   logic signed [SUM_W-1:0]      running_sum;
   logic [5:0]                   ring_pos;
   logic                         refill_pending;
   logic signed [SAMPLE_W-1:0]   first_value;
   logic [CFG_BITS-1:0]          refill_count;

   logic signed [SAMPLE_W-1:0]   expected_averages [$];
   int                           mismatch_count = 0;
   int                           cycle_count = 0;

   // Long hold-off request, handed to the stall process by a toggle.
   int                           hold_len = 0;
   bit                           hold_toggle = 1'b0;

   moving_average_filter u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_average       (rsp_average),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Fold one sample into the predicted window and return the expected mean.
   function automatic logic signed [SAMPLE_W-1:0] predict_average(
      input logic signed [SAMPLE_W-1:0] value
   );
      int                         win;
      int                         next_pos;
      int                         quotient;
      logic signed [SAMPLE_W-1:0] oldest;
      win = (window_reg == 0) ? 1 : ((window_reg > RING_DEPTH) ? RING_DEPTH : window_reg);
      // The first sample after a re-arm stands for the whole window.
      if (refill_pending) begin
         refill_pending = 1'b0;
         first_value = value;
         running_sum = SUM_W'(int'(value) * win);
         refill_count = '0;
         if (ring_pos >= win) begin
            ring_pos = '0;
         end
         return value;
      end
      next_pos = ring_pos + 1;
      if (next_pos >= win) begin
         next_pos = 0;
      end
      ring_pos = next_pos[5:0];
      // Entries not yet overwritten still hold the first sample.
      oldest = (refill_count < win) ? first_value : ring_model[next_pos];
      running_sum = running_sum - oldest + value;
      ring_model[next_pos] = value;
      if (refill_count < win) begin
         refill_count++;
      end
      quotient = int'(running_sum) / win;
      return quotient[SAMPLE_W-1:0];
   endfunction

   // Track every transfer on the three channels and check each result.
   always @(posedge clock) begin : track_transfers
      logic signed [SAMPLE_W-1:0] want;
      if (reset) begin
         window_reg     = CFG_RESET;
         running_sum    = '0;
         ring_pos       = '0;
         refill_pending = 1'b1;
         first_value    = '0;
         refill_count   = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            window_reg     = csr_window_length;
            ring_pos       = '0;
            refill_count   = '0;
            refill_pending = 1'b1;
         end
         if (req_valid && !req_stall) begin
            expected_averages.push_back(predict_average(req_sample));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_averages.size() == 0) begin
               $error("average: unexpected result, actual %0d", rsp_average);
               mismatch_count++;
            end else begin
               want = expected_averages.pop_front();
               if (rsp_average !== want) begin
                  $error("average: expected %0d, actual %0d", want, rsp_average);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Receiver stall pattern, with a long hold-off when one is requested.
   always @(negedge clock) begin : drive_stall
      static stall_pattern_type pattern = STALL_OFF;
      static int                stretch_left = 0;
      static int                hold_left = 0;
      static bit                hold_seen = 1'b0;
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (stretch_left == 0) begin
            pattern      = stall_pattern_type'($urandom_range(0, 3));
            stretch_left = $urandom_range(20, 200);
         end
         stretch_left--;
         unique case (pattern)
            STALL_OFF:      rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
            default:        rsp_stall <= ((cycle_count % 7) < 3);
         endcase
      end
   end

   // Offer one sample and hold it until its transfer; returns at a falling edge.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
      req_sample = value;
      req_valid  = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Wait until every expected average has arrived and the block has settled.
   task automatic wait_for_drain();
      while (expected_averages.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write the window length once the block is idle.
   task automatic write_window(input logic [CFG_BITS-1:0] length);
      req_valid = 1'b0;
      wait_for_drain();
      csr_window_length = length;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Pick a sample, biased toward the extremes and small values.
   function automatic logic signed [SAMPLE_W-1:0] random_sample(input bit extremes_only);
      int pick;
      pick = $urandom_range(0, 9);
      if (extremes_only) begin
         return pick[0] ? 16'sh7fff : 16'sh8000;
      end
      case (pick)
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2, 3:    return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Send a stream of random samples in bursts with random gaps between them.
   task automatic send_stream(input int count, input bit extremes_only);
      int burst_left;
      burst_left = $urandom_range(1, 40);
      for (int i = 0; i < count; i++) begin
         send_sample(random_sample(extremes_only));
         burst_left--;
         if (burst_left == 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12))
               @(negedge clock);
            burst_left = $urandom_range(1, 40);
         end
      end
      req_valid = 1'b0;
   endtask

   // Extremes at the reset window: the first one is returned unchanged.
   task automatic test_first_sample();
      send_sample(16'sh8000);
      send_sample(16'sh7fff);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      send_sample(16'sd0);
      send_sample(16'sh5555);
      send_sample(16'shaaaa);
      send_sample(16'sh7fff);
      req_valid = 1'b0;
   endtask

   // A window of zero acts as a window of one.
   task automatic test_window_zero();
      write_window('0);
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      send_sample(16'sd5);
      req_valid = 1'b0;
   endtask

   // A window above the ring depth acts as the full depth.
   task automatic test_window_oversize();
      write_window('1);
      send_sample(16'sh8000);
      send_sample(16'sh8000);
      send_sample(16'sh7fff);
      send_sample(-16'sd1);
      req_valid = 1'b0;
   endtask

   // Rewriting the same window re-arms first-sample handling.
   task automatic test_window_rearm();
      write_window(CFG_BITS'(3));
      send_sample(16'sd100);
      send_sample(-16'sd7);
      send_sample(16'sd20);
      write_window(CFG_BITS'(3));
      send_sample(16'sh8000);
      send_sample(16'sh7fff);
      req_valid = 1'b0;
   endtask

   // Random streams over a series of windows, the extremes among them.
   task automatic test_random_phases();
      logic [CFG_BITS-1:0] length;
      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0:       length = CFG_BITS'(RING_DEPTH);
            1:       length = CFG_BITS'(1);
            2:       length = '0;
            3:       length = '1;
            4:       length = CFG_BITS'(2);
            5:       length = CFG_BITS'(RING_DEPTH + 1);
            default: length = ($urandom_range(0, 3) == 0) ? CFG_BITS'($urandom_range(0, 127))
                                                          : CFG_BITS'($urandom_range(1, 64));
         endcase
         write_window(length);
         send_stream(125, $urandom_range(0, 3) == 0);
      end
   endtask

   // Hold the receiver off for a long stretch while samples keep coming.
   task automatic test_backpressure();
      write_window(CFG_BITS'($urandom_range(1, 64)));
      hold_len = 400;
      hold_toggle = ~hold_toggle;
      for (int i = 0; i < 30; i++) begin
         send_sample(random_sample(1'b0));
      end
      req_valid = 1'b0;
   endtask

   // Test sequence.
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_sample        = '0;
      csr_valid         = 1'b0;
      csr_window_length = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_first_sample();
      test_window_zero();
      test_window_oversize();
      test_window_rearm();
      test_backpressure();
      test_random_phases();

      wait_for_drain();
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
